// ----- hw/rtl/bra_pkg.sv -----
// bra_pkg: shared types, codes and defaults of the banker's resource allocator
// used by bra_ctrl, bra_datapath and bankers_resource_allocator; no dependencies

package bra_pkg;

   localparam int DEF_NUM_CUSTOMERS = 8;
   localparam int DEF_NUM_RESOURCES = 3;
   localparam int DEF_AMOUNT_WIDTH  = 8;

   // fixed field widths of the stream and csr ports
   localparam int FIELD_W    = 8;
   localparam int ACTION_W   = 2;
   localparam int CUSTOMER_W = 3;
   localparam int STATUS_W   = 3;
   localparam int MAX_RES    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLAIM   = 2'd0,
      ACT_REQUEST = 2'd1,
      ACT_RELEASE = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE         = 3'd0,
      ST_EXCEEDS      = 3'd1,
      ST_WAIT         = 3'd2,
      ST_UNSAFE       = 3'd3,
      ST_OVER_RELEASE = 3'd4,
      ST_CLAIM_LOW    = 3'd5
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic check;
      logic walk_init;
      logic walk_step;
      logic finish;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic need_walk;
   } sts_type;

endpackage

// ----- hw/rtl/bra_datapath.sv -----
// bra_datapath: claim and held tables, column sums, checks and safety walk
// depends on bra_pkg; sequenced by bra_ctrl

module bra_datapath #(
   parameter int NUM_CUSTOMERS = bra_pkg::DEF_NUM_CUSTOMERS,
   parameter int NUM_RESOURCES = bra_pkg::DEF_NUM_RESOURCES,
   parameter int AMOUNT_WIDTH  = bra_pkg::DEF_AMOUNT_WIDTH,
   localparam int CW = (NUM_CUSTOMERS > 1) ? $clog2(NUM_CUSTOMERS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bra_pkg::cmd_type                    cmd,
   input  logic [CW-1:0]                       walk_row,
   output bra_pkg::sts_type                    sts,
   input  logic                                csr_we,
   input  logic [bra_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bra_pkg::FIELD_W-1:0]         csr_wdata,
   input  logic [bra_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic [bra_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int AW = AMOUNT_WIDTH;
   localparam int SW = AMOUNT_WIDTH + CW + 1;
   localparam int FW = bra_pkg::FIELD_W;

   logic [FW-1:0]            total_ff [bra_pkg::MAX_RES];
   logic [AW-1:0]            claim_ff [NUM_CUSTOMERS][NUM_RESOURCES];
   logic [AW-1:0]            held_ff  [NUM_CUSTOMERS][NUM_RESOURCES];
   logic [SW-1:0]            sum_ff   [NUM_RESOURCES];
   logic [SW-1:0]            work_ff  [NUM_RESOURCES];
   logic [NUM_CUSTOMERS-1:0] done_ff;
   bra_pkg::action_type      action_ff;
   logic [bra_pkg::CUSTOMER_W-1:0] cust_ff;
   logic [AW-1:0]            amt_ff   [NUM_RESOURCES];
   bra_pkg::status_type      status_ff;

   logic [CW-1:0]            row;
   logic [CW-1:0]            cust_row;
   logic                     in_range;
   logic [AW-1:0]            total_eff [NUM_RESOURCES];
   logic [AW-1:0]            free_amt  [NUM_RESOURCES];
   logic [AW-1:0]            need      [NUM_RESOURCES];
   logic                     claim_low, exceeds, wait_free, over_rel, fits;
   logic [FW-1:0]            free_out  [bra_pkg::MAX_RES];

   assign cust_row = CW'({1'b0, cust_ff});
   assign in_range = ({1'b0, cust_ff} < (bra_pkg::CUSTOMER_W + 1)'(NUM_CUSTOMERS));
   assign row      = (cmd.walk_step) ? walk_row : cust_row;

   always_comb begin
      claim_low = 1'b0;
      exceeds   = 1'b0;
      wait_free = 1'b0;
      over_rel  = 1'b0;
      fits      = 1'b1;
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         total_eff[r] = AW'(total_ff[r]);
         free_amt[r]  = (SW'(total_eff[r]) > sum_ff[r]) ?
                        AW'(SW'(total_eff[r]) - sum_ff[r]) : '0;
         need[r]      = (claim_ff[row][r] > held_ff[row][r]) ?
                        (claim_ff[row][r] - held_ff[row][r]) : '0;
         if (amt_ff[r] < held_ff[row][r]) claim_low = 1'b1;
         if (amt_ff[r] > need[r])         exceeds   = 1'b1;
         if (amt_ff[r] > free_amt[r])     wait_free = 1'b1;
         if (amt_ff[r] > held_ff[row][r]) over_rel  = 1'b1;
         if (SW'(need[r]) > work_ff[r])   fits      = 1'b0;
      end
      for (int r = 0; r < bra_pkg::MAX_RES; r++) begin
         free_out[r] = '0;
      end
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         free_out[r] = FW'(free_amt[r]);
      end
   end

   assign sts.need_walk = in_range && (action_ff == bra_pkg::ACT_REQUEST) &&
                          !exceeds && !wait_free;

   assign rsp_tdata = {5'd0, free_out[2], free_out[1], free_out[0], status_ff};

   // configuration totals
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < bra_pkg::MAX_RES; r++) total_ff[r] <= '0;
      end else if (csr_we && (csr_index < bra_pkg::CSR_IDX_W'(bra_pkg::MAX_RES))) begin
         total_ff[csr_index] <= csr_wdata;
      end
   end

   // captured transaction and result status
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= bra_pkg::action_type'(req_tdata[1:0]);
         cust_ff   <= req_tdata[4:2];
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            amt_ff[r] <= AW'(req_tdata[5 + r*FW +: FW]);
         end
      end
      if (cmd.check) begin
         status_ff <= bra_pkg::ST_DONE;
         if (in_range) begin
            unique case (action_ff)
               bra_pkg::ACT_CLAIM: begin
                  if (claim_low) status_ff <= bra_pkg::ST_CLAIM_LOW;
               end
               bra_pkg::ACT_REQUEST: begin
                  if (exceeds)        status_ff <= bra_pkg::ST_EXCEEDS;
                  else if (wait_free) status_ff <= bra_pkg::ST_WAIT;
               end
               bra_pkg::ACT_RELEASE: begin
                  if (over_rel) status_ff <= bra_pkg::ST_OVER_RELEASE;
               end
               default: begin
               end
            endcase
         end
      end else if (cmd.finish && !(&done_ff)) begin
         status_ff <= bra_pkg::ST_UNSAFE;
      end
   end

   // tables and column sums
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CUSTOMERS; c++) begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               claim_ff[c][r] <= '0;
               held_ff[c][r]  <= '0;
            end
         end
         for (int r = 0; r < NUM_RESOURCES; r++) sum_ff[r] <= '0;
      end else if (cmd.check && in_range) begin
         unique case (action_ff)
            bra_pkg::ACT_CLAIM: begin
               if (!claim_low) begin
                  for (int r = 0; r < NUM_RESOURCES; r++) claim_ff[row][r] <= amt_ff[r];
               end
            end
            bra_pkg::ACT_REQUEST: begin
               // tentative grant, undone after the walk if unsafe
               if (!exceeds && !wait_free) begin
                  for (int r = 0; r < NUM_RESOURCES; r++) begin
                     held_ff[row][r] <= held_ff[row][r] + amt_ff[r];
                     sum_ff[r]       <= sum_ff[r] + SW'(amt_ff[r]);
                  end
               end
            end
            bra_pkg::ACT_RELEASE: begin
               if (!over_rel) begin
                  for (int r = 0; r < NUM_RESOURCES; r++) begin
                     held_ff[row][r] <= held_ff[row][r] - amt_ff[r];
                     sum_ff[r]       <= sum_ff[r] - SW'(amt_ff[r]);
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.finish && !(&done_ff)) begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            held_ff[row][r] <= held_ff[row][r] - amt_ff[r];
            sum_ff[r]       <= sum_ff[r] - SW'(amt_ff[r]);
         end
      end
   end

   // safety walk work vector and finished flags
   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         done_ff <= '0;
         for (int r = 0; r < NUM_RESOURCES; r++) work_ff[r] <= SW'(free_amt[r]);
      end else if (cmd.walk_step && !done_ff[walk_row] && fits) begin
         done_ff[walk_row] <= 1'b1;
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            work_ff[r] <= work_ff[r] + SW'(held_ff[walk_row][r]);
         end
      end
   end

endmodule

// ----- hw/rtl/bra_ctrl.sv -----
// bra_ctrl: sequencing state machine and walk counters of the allocator
// depends on bra_pkg; drives bra_datapath through cmd_type

module bra_ctrl #(
   parameter int NUM_CUSTOMERS = bra_pkg::DEF_NUM_CUSTOMERS,
   localparam int CW = (NUM_CUSTOMERS > 1) ? $clog2(NUM_CUSTOMERS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  bra_pkg::sts_type sts,
   output bra_pkg::cmd_type cmd,
   output logic [CW-1:0]    walk_row
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_INIT   = 6'b000100,
      S_WALK   = 6'b001000,
      S_FINISH = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   localparam logic [CW-1:0] LAST = CW'(NUM_CUSTOMERS - 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] pass_ff, pass_in;
   logic          last_step;

   assign last_step  = (row_ff == LAST) && (pass_ff == LAST);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign walk_row   = row_ff;

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.need_walk ? S_INIT : S_RESP;
         end
         S_INIT: begin
            cmd.walk_init = 1'b1;
            row_in   = '0;
            pass_in  = '0;
            state_in = S_WALK;
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (row_ff == LAST) begin
               row_in  = '0;
               pass_in = pass_ff + 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
            if (last_step) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= '0;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         pass_ff  <= pass_in;
      end
   end

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && last_step) |=> (state_ff == S_FINISH))
      else $error("walk did not end after the last pass");

   a_check_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |=> (state_ff == S_INIT || state_ff == S_RESP))
      else $error("check not followed by walk or response");

   a_resp_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_RESP) |->
         ($past(state_ff) == S_CHECK || $past(state_ff) == S_FINISH))
      else $error("response entered from wrong state");

   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |=> (state_ff == S_WALK && row_ff == '0 && pass_ff == '0))
      else $error("walk started with stale counters");

endmodule

// ----- hw/rtl/bankers_resource_allocator.sv -----
// bankers_resource_allocator: top level of the banker's deadlock-avoidance allocator
// depends on bra_pkg, bra_ctrl and bra_datapath

// Handles one transaction at a time. Claim, release, out-of-range and unknown
// transactions, and requests refused by the need or free check, go from check
// straight to the response. A request that passes the need and free checks
// runs the safety walk, one customer row per cycle over NUM_CUSTOMERS passes,
// through walk setup, the walk and the rollback decision before the response;
// the walk length comes from the single-row read of the held/claim tables.
// A new transaction is taken from the cycle after the response has been
// accepted. Free amounts are kept from running column sums so they are
// always available without a sweep. The user must write totals through the csr
// port only while the block is idle; the block itself does not enforce this.

module bankers_resource_allocator #(
   parameter int NUM_CUSTOMERS = bra_pkg::DEF_NUM_CUSTOMERS,
   parameter int NUM_RESOURCES = bra_pkg::DEF_NUM_RESOURCES,
   parameter int AMOUNT_WIDTH  = bra_pkg::DEF_AMOUNT_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // action[1:0], customer[4:2], amount_a[12:5], amount_b[20:13], amount_c[28:21]
   input  logic [bra_pkg::REQ_DATA_W-1:0]  req_tdata,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[2:0], free_a[10:3], free_b[18:11], free_c[26:19]
   output logic [bra_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // csr write port: 0 total_res_a, 1 total_res_b, 2 total_res_c
   input  logic                            csr_we,
   input  logic [bra_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bra_pkg::FIELD_W-1:0]     csr_wdata
);

   localparam int CW = (NUM_CUSTOMERS > 1) ? $clog2(NUM_CUSTOMERS) : 1;

   bra_pkg::cmd_type cmd;
   bra_pkg::sts_type sts;
   logic [CW-1:0]    walk_row;

   // sequencing: idle, check, walk setup, walk, rollback decision, response
   bra_ctrl #(
      .NUM_CUSTOMERS (NUM_CUSTOMERS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd),
      .walk_row   (walk_row)
   );

   // tables, running held sums, checks and work vector
   bra_datapath #(
      .NUM_CUSTOMERS (NUM_CUSTOMERS),
      .NUM_RESOURCES (NUM_RESOURCES),
      .AMOUNT_WIDTH  (AMOUNT_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .walk_row  (walk_row),
      .sts       (sts),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
